// ===== hdl/drcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the disk request chunk splitter.
// No dependencies; imported by the shared adder and the top level.
package drcs_pkg;

  // Request and chunk geometry
  localparam int MAX_REQUEST_BYTES = 2097152;
  localparam int SECTOR_BYTES      = 512;
  localparam int READ_CHUNK_BYTES  = 524288;
  localparam int MIN_READ_BYTES    = 65536;
  localparam int READ_ALIGN_BYTES  = 4096;
  localparam int WRITE_CHUNK_BYTES = 131072;
  localparam int CHUNK_THRESHOLD   = 128 * 1024;
  localparam int MAX_RESULTS       = 32;

  localparam int SEC_W = $clog2(SECTOR_BYTES);
  localparam int RA_W  = $clog2(READ_ALIGN_BYTES);
  localparam int WC_W  = $clog2(WRITE_CHUNK_BYTES);
  localparam int N_W   = $clog2(MAX_RESULTS);

  // Datapath widths
  localparam int OFF_W  = 48;
  localparam int RLEN_W = 32;
  localparam int HDR_W  = 21;
  localparam int LEN_W  = 22;
  localparam int CLEN_W = 23;
  localparam int DOF_W  = 50;
  localparam int IDX_W  = 3;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 144;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_REDIRECT_ENABLE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_LENGTH      = 3'd1;
  localparam logic [IDX_W-1:0] REG_STORAGE_OFFSET     = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLUME_SIZE        = 3'd3;
  localparam logic [IDX_W-1:0] REG_SSD_CHUNKING       = 3'd4;
  localparam logic [IDX_W-1:0] REG_CONVERSION_ACTIVE  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ENCRYPTED_BOUNDARY = 3'd6;
  localparam logic [IDX_W-1:0] REG_REENCRYPT_MODE     = 3'd7;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DENIED  = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // Key selection codes
  localparam logic [1:0] KEY_NONE   = 2'd0;
  localparam logic [1:0] KEY_VOLUME = 2'd1;
  localparam logic [1:0] KEY_TEMP   = 2'd2;

  typedef struct packed {
    logic             sub;
    logic [DOF_W-1:0] a;
    logic [DOF_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DOF_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

// ===== hdl/drcs_alu.sv =====
`timescale 1ns / 1ps
// Shared wide adder/subtractor used by every arithmetic step of the sequencer.
// Depends on drcs_pkg for the request and response structs.
module drcs_alu (
  input  drcs_pkg::alu_req_t req,
  output drcs_pkg::alu_rsp_t rsp
);
  import drcs_pkg::*;

  logic [DOF_W:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res    = sum[DOF_W-1:0];
    rsp.borrow = req.sub & sum[DOF_W];
  end

endmodule

// ===== hdl/disk_request_chunk_splitter.sv =====
`timescale 1ns / 1ps
// Disk request chunk splitter: checks one request and splits it into chunks.
// Depends on drcs_pkg and the shared adder drcs_alu.
//
// One request is handled at a time; in_tready is high only while the block is
// idle. All wide offset arithmetic runs through a single 50-bit adder/subtractor,
// one operation per cycle. The checks run after the input transfer; a refused
// request then yields one status result. An accepted request yields its chunks
// one at a time, each computed after the previous chunk's transfer. Configuration
// writes are taken at any time and must only be issued while the block is idle.
module disk_request_chunk_splitter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // request_offset[47:0], request_length[79:48], sole_request[80], zero pad
  input  logic [drcs_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // disk_offset[47:0], chunk_bytes[69:48], buffer_offset[91:70],
  // key_select[93:92], tweak_offset[141:94], discontinuous[142], zero pad
  output logic [drcs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drcs_pkg::IDX_W-1:0]       cfg_index,
  input  logic [drcs_pkg::OFF_W-1:0]       cfg_data
);
  import drcs_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_END     = 4'd1;
  localparam logic [3:0] ST_SHL     = 4'd2;
  localparam logic [3:0] ST_CMP_HDR = 4'd3;
  localparam logic [3:0] ST_CMP_STO = 4'd4;
  localparam logic [3:0] ST_CMP_VOL = 4'd5;
  localparam logic [3:0] ST_BASE    = 4'd6;
  localparam logic [3:0] ST_DOF     = 4'd7;
  localparam logic [3:0] ST_HDR     = 4'd8;
  localparam logic [3:0] ST_RED     = 4'd9;
  localparam logic [3:0] ST_BND     = 4'd10;
  localparam logic [3:0] ST_CUT     = 4'd11;
  localparam logic [3:0] ST_OUT     = 4'd12;

  // Configuration
  logic              redirect_enable_r;
  logic [HDR_W-1:0]  header_length_r;
  logic [OFF_W-1:0]  storage_offset_r;
  logic [OFF_W-1:0]  volume_size_r;
  logic              ssd_chunking_r;
  logic              conversion_active_r;
  logic [OFF_W-1:0]  encrypted_boundary_r;
  logic              reencrypt_mode_r;

  // Control
  logic [3:0]        state_r, state_nxt;
  logic [OFF_W-1:0]  exp_r, exp_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working payload
  logic              op_r, op_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [RLEN_W-1:0] len_r, len_nxt;
  logic              sole_r, sole_nxt;
  logic [DOF_W-1:0]  end_r, end_nxt;
  logic [DOF_W-1:0]  shl_r, shl_nxt;
  logic              below_hdr_end_r, below_hdr_end_nxt;
  logic              sto_below_end_r, sto_below_end_nxt;
  logic              past_vol_r, past_vol_nxt;
  logic [DOF_W-1:0]  base_r, base_nxt;
  logic              chunking_r, chunking_nxt;
  logic [LEN_W-1:0]  done_r, done_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [DOF_W-1:0]  dof_r, dof_nxt;
  logic [DOF_W-1:0]  tw_r, tw_nxt;
  logic              hdr_r, hdr_nxt;
  logic [CLEN_W-1:0] clen_r, clen_nxt;
  logic [DOF_W-1:0]  diff_r, diff_nxt;
  logic              ge_r, ge_nxt;

  // Output register
  logic [1:0]        o_status_r, o_status_nxt;
  logic [OFF_W-1:0]  o_dof_r, o_dof_nxt;
  logic [LEN_W-1:0]  o_clen_r, o_clen_nxt;
  logic [LEN_W-1:0]  o_boff_r, o_boff_nxt;
  logic [1:0]        o_key_r, o_key_nxt;
  logic [OFF_W-1:0]  o_tw_r, o_tw_nxt;
  logic              o_disc_r, o_disc_nxt;
  logic              o_last_r, o_last_nxt;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Chunk sizing
  logic              first;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  rd_half, rd_l1, rd_left, rd_l2;
  logic [RA_W-1:0]   rd_mis;
  logic [CLEN_W-1:0] rd_len;
  logic [WC_W-1:0]   wr_mis;
  logic [CLEN_W-1:0] wr_len;
  logic [CLEN_W-1:0] clen_cut;
  logic [LEN_W-1:0]  clen_fin;
  logic [1:0]        key;
  logic              deny, invalid;

  drcs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {1'b0, o_disc_r, o_tw_r, o_key_r, o_boff_r, o_clen_r, o_dof_r};

  assign first   = (done_r == '0);
  assign rem     = len_r[LEN_W-1:0] - done_r;

  assign rd_half = rem >> 1;
  assign rd_l1   = (rd_half > LEN_W'(READ_CHUNK_BYTES)) ? LEN_W'(READ_CHUNK_BYTES) : rd_half;
  assign rd_left = rem - rd_l1;
  assign rd_l2   = (rd_left < LEN_W'(MIN_READ_BYTES)) ? rem : rd_l1;
  assign rd_mis  = base_r[RA_W-1:0] + rd_l2[RA_W-1:0];
  assign rd_len  = CLEN_W'(rd_l2) + ((first && rd_mis != '0) ?
                   CLEN_W'(READ_ALIGN_BYTES) - CLEN_W'(rd_mis) : '0);
  assign wr_mis  = base_r[WC_W-1:0];
  assign wr_len  = CLEN_W'(WRITE_CHUNK_BYTES) + ((first && wr_mis != '0) ?
                   CLEN_W'(WRITE_CHUNK_BYTES) - CLEN_W'(wr_mis) : '0);

  assign clen_cut = (conversion_active_r && !ge_r && (DOF_W'(clen_r) > diff_r)) ?
                    diff_r[CLEN_W-1:0] : clen_r;
  assign clen_fin = ((clen_cut > CLEN_W'(rem)) || (clen_cut == '0) ||
                     (n_r == N_W'(MAX_RESULTS - 1))) ? rem : clen_cut[LEN_W-1:0];
  assign key      = (conversion_active_r && ge_r) ?
                    (reencrypt_mode_r ? KEY_TEMP : KEY_NONE) : KEY_VOLUME;

  assign deny    = op_r && redirect_enable_r && (len_r != '0) && (header_length_r != '0) &&
                   below_hdr_end_r && sto_below_end_r;
  assign invalid = (len_r == '0) || (len_r[SEC_W-1:0] != '0) ||
                   (len_r > RLEN_W'(MAX_REQUEST_BYTES)) || past_vol_r;

  // Shared adder operand selection
  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_END: begin
        alu_req.a = DOF_W'(off_r);
        alu_req.b = DOF_W'(len_r);
      end
      ST_SHL: begin
        alu_req.a = DOF_W'(storage_offset_r);
        alu_req.b = DOF_W'(header_length_r);
      end
      ST_CMP_HDR: begin
        alu_req.sub = 1'b1;
        alu_req.a   = DOF_W'(off_r);
        alu_req.b   = shl_r;
      end
      ST_CMP_STO: begin
        alu_req.sub = 1'b1;
        alu_req.a   = DOF_W'(storage_offset_r);
        alu_req.b   = end_r;
      end
      ST_CMP_VOL: begin
        alu_req.sub = 1'b1;
        alu_req.a   = DOF_W'(volume_size_r);
        alu_req.b   = end_r;
      end
      ST_BASE: begin
        alu_req.a = DOF_W'(off_r);
        alu_req.b = redirect_enable_r ? '0 : DOF_W'(header_length_r);
      end
      ST_DOF: begin
        alu_req.a = base_r;
        alu_req.b = DOF_W'(done_r);
      end
      ST_HDR: begin
        alu_req.sub = 1'b1;
        alu_req.a   = dof_r;
        alu_req.b   = DOF_W'(header_length_r);
      end
      ST_RED: begin
        alu_req.a = dof_r;
        alu_req.b = hdr_r ? DOF_W'(storage_offset_r) : '0;
      end
      ST_BND: begin
        alu_req.sub = 1'b1;
        alu_req.a   = DOF_W'(encrypted_boundary_r);
        alu_req.b   = dof_r;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    exp_nxt           = exp_r;
    out_valid_nxt     = out_valid_r;
    op_nxt            = op_r;
    off_nxt           = off_r;
    len_nxt           = len_r;
    sole_nxt          = sole_r;
    end_nxt           = end_r;
    shl_nxt           = shl_r;
    below_hdr_end_nxt = below_hdr_end_r;
    sto_below_end_nxt = sto_below_end_r;
    past_vol_nxt      = past_vol_r;
    base_nxt          = base_r;
    chunking_nxt      = chunking_r;
    done_nxt          = done_r;
    n_nxt             = n_r;
    dof_nxt           = dof_r;
    tw_nxt            = tw_r;
    hdr_nxt           = hdr_r;
    clen_nxt          = clen_r;
    diff_nxt          = diff_r;
    ge_nxt            = ge_r;
    o_status_nxt      = o_status_r;
    o_dof_nxt         = o_dof_r;
    o_clen_nxt        = o_clen_r;
    o_boff_nxt        = o_boff_r;
    o_key_nxt         = o_key_r;
    o_tw_nxt          = o_tw_r;
    o_disc_nxt        = o_disc_r;
    o_last_nxt        = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          off_nxt   = in_tdata[OFF_W-1:0];
          len_nxt   = in_tdata[OFF_W +: RLEN_W];
          sole_nxt  = in_tdata[OFF_W + RLEN_W];
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        end_nxt   = alu_rsp.res;
        state_nxt = ST_SHL;
      end
      ST_SHL: begin
        shl_nxt   = alu_rsp.res;
        state_nxt = ST_CMP_HDR;
      end
      ST_CMP_HDR: begin
        below_hdr_end_nxt = alu_rsp.borrow;
        state_nxt         = ST_CMP_STO;
      end
      ST_CMP_STO: begin
        sto_below_end_nxt = alu_rsp.borrow;
        state_nxt         = ST_CMP_VOL;
      end
      ST_CMP_VOL: begin
        past_vol_nxt = alu_rsp.borrow;
        state_nxt    = ST_BASE;
      end
      ST_BASE: begin
        if (deny || invalid) begin
          o_status_nxt  = deny ? STATUS_DENIED : STATUS_INVALID;
          o_dof_nxt     = '0;
          o_clen_nxt    = '0;
          o_boff_nxt    = '0;
          o_key_nxt     = KEY_NONE;
          o_tw_nxt      = '0;
          o_disc_nxt    = 1'b0;
          o_last_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          base_nxt     = alu_rsp.res;
          exp_nxt      = end_r[OFF_W-1:0];
          chunking_nxt = ssd_chunking_r && sole_r && (exp_r == off_r) &&
                         (len_r >= RLEN_W'(CHUNK_THRESHOLD));
          done_nxt     = '0;
          n_nxt        = '0;
          state_nxt    = ST_DOF;
        end
      end
      ST_DOF: begin
        dof_nxt   = alu_rsp.res;
        state_nxt = ST_HDR;
      end
      ST_HDR: begin
        hdr_nxt = redirect_enable_r && alu_rsp.borrow;
        tw_nxt  = alu_rsp.res;
        if (redirect_enable_r && alu_rsp.borrow) begin
          clen_nxt = CLEN_W'(header_length_r);
        end else if (chunking_r) begin
          clen_nxt = op_r ? wr_len : rd_len;
        end else begin
          clen_nxt = len_r[CLEN_W-1:0];
        end
        state_nxt = ST_RED;
      end
      ST_RED: begin
        dof_nxt = alu_rsp.res;
        if (redirect_enable_r) begin
          tw_nxt = alu_rsp.res;
        end
        state_nxt = ST_BND;
      end
      ST_BND: begin
        diff_nxt  = alu_rsp.res;
        ge_nxt    = alu_rsp.borrow || (alu_rsp.res == '0);
        state_nxt = ST_CUT;
      end
      ST_CUT: begin
        o_status_nxt  = STATUS_OK;
        o_dof_nxt     = dof_r[OFF_W-1:0];
        o_clen_nxt    = clen_fin;
        o_boff_nxt    = done_r;
        o_key_nxt     = key;
        o_tw_nxt      = (key != KEY_NONE) ? tw_r[OFF_W-1:0] : '0;
        o_disc_nxt    = hdr_r;
        o_last_nxt    = (clen_fin == rem);
        done_nxt      = done_r + clen_fin;
        n_nxt         = n_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = o_last_r ? ST_IDLE : ST_DOF;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      redirect_enable_r    <= 1'b1;
      header_length_r      <= '0;
      storage_offset_r     <= '0;
      volume_size_r        <= '0;
      ssd_chunking_r       <= 1'b0;
      conversion_active_r  <= 1'b0;
      encrypted_boundary_r <= '0;
      reencrypt_mode_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REDIRECT_ENABLE:    redirect_enable_r    <= cfg_data[0];
        REG_HEADER_LENGTH:      header_length_r      <= cfg_data[HDR_W-1:0];
        REG_STORAGE_OFFSET:     storage_offset_r     <= cfg_data;
        REG_VOLUME_SIZE:        volume_size_r        <= cfg_data;
        REG_SSD_CHUNKING:       ssd_chunking_r       <= cfg_data[0];
        REG_CONVERSION_ACTIVE:  conversion_active_r  <= cfg_data[0];
        REG_ENCRYPTED_BOUNDARY: encrypted_boundary_r <= cfg_data;
        REG_REENCRYPT_MODE:     reencrypt_mode_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    off_r           <= off_nxt;
    len_r           <= len_nxt;
    sole_r          <= sole_nxt;
    end_r           <= end_nxt;
    shl_r           <= shl_nxt;
    below_hdr_end_r <= below_hdr_end_nxt;
    sto_below_end_r <= sto_below_end_nxt;
    past_vol_r      <= past_vol_nxt;
    base_r          <= base_nxt;
    chunking_r      <= chunking_nxt;
    done_r          <= done_nxt;
    n_r             <= n_nxt;
    dof_r           <= dof_nxt;
    tw_r            <= tw_nxt;
    hdr_r           <= hdr_nxt;
    clen_r          <= clen_nxt;
    diff_r          <= diff_nxt;
    ge_r            <= ge_nxt;
    o_status_r      <= o_status_nxt;
    o_dof_r         <= o_dof_nxt;
    o_clen_r        <= o_clen_nxt;
    o_boff_r        <= o_boff_nxt;
    o_key_r         <= o_key_nxt;
    o_tw_r          <= o_tw_nxt;
    o_disc_r        <= o_disc_nxt;
    o_last_r        <= o_last_nxt;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for disk_request_chunk_splitter: directed and random disk requests
// are checked chunk by chunk against an in-bench splitter prediction.
// Depends on drcs_pkg and the splitter RTL only.
module tb;
  import drcs_pkg::*;

  localparam logic [63:0] TOP48     = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_REQ   = 64'(MAX_REQUEST_BYTES);
  localparam logic [63:0] SECTOR    = 64'(SECTOR_BYTES);
  localparam logic [63:0] RD_CHUNK  = 64'(READ_CHUNK_BYTES);
  localparam logic [63:0] RD_MIN    = 64'(MIN_READ_BYTES);
  localparam logic [63:0] RD_ALIGN  = 64'(READ_ALIGN_BYTES);
  localparam logic [63:0] WR_CHUNK  = 64'(WRITE_CHUNK_BYTES);
  localparam logic [63:0] SSD_MIN   = 64'(CHUNK_THRESHOLD);
  localparam int          SETTLE_CYCLES = 20;

  typedef struct packed {
    logic        redirect;
    logic [20:0] header_len;
    logic [47:0] storage;
    logic [47:0] volume;
    logic        ssd;
    logic        converting;
    logic [47:0] boundary;
    logic        reencrypt;
  } volume_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] disk_offset;
    logic [21:0] chunk_bytes;
    logic [21:0] buffer_offset;
    logic [1:0]  key_select;
    logic [47:0] tweak_offset;
    logic        discontinuous;
    logic        last;
  } chunk_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [OFF_W-1:0]      cfg_data = '0;

  volume_cfg_t vcfg;
  logic [47:0] next_offset;
  chunk_t      chunk_q[$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  disk_request_chunk_splitter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void split_request(input logic op, input logic [47:0] off,
                                        input logic [31:0] len, input logic sole);
    logic [63:0] o, l, hl, stor, base, done, rem, dof, clen, r, tw;
    logic [1:0]  key;
    logic        disc, seq, ssd;
    int          n;
    chunk_t      c;
    o = {16'd0, off};
    l = {32'd0, len};
    hl = {43'd0, vcfg.header_len};
    stor = {16'd0, vcfg.storage};
    c = '0;
    c.last = 1'b1;
    if (op && vcfg.redirect && l != 0 && hl != 0 && o < stor + hl && stor < o + l) begin
      c.status = STATUS_DENIED;
    end else if (l == 0 || l % SECTOR != 0 || l > MAX_REQ || o + l > {16'd0, vcfg.volume}) begin
      c.status = STATUS_INVALID;
    end
    if (c.status != STATUS_OK) begin
      chunk_q.push_back(c);
      return;
    end
    seq = (next_offset == off);
    base = o + l;
    next_offset = base[47:0];
    base = vcfg.redirect ? o : o + hl;
    ssd = vcfg.ssd && sole && seq && l >= SSD_MIN;
    done = '0;
    n = 0;
    while (done < l && n < MAX_RESULTS) begin
      rem = l - done;
      dof = base + done;
      key = KEY_VOLUME;
      disc = 1'b0;
      tw = '0;
      if (vcfg.redirect && dof < hl) begin
        dof = dof + stor;
        clen = hl;
        disc = 1'b1;
      end else if (ssd && op) begin
        clen = WR_CHUNK;
        r = (base + clen) % WR_CHUNK;
        if (done == 0 && r != 0) clen = clen + WR_CHUNK - r;
      end else if (ssd) begin
        clen = rem / 2;
        if (clen > RD_CHUNK) clen = RD_CHUNK;
        if (rem - clen < RD_MIN) clen = rem;
        r = (base + clen) % RD_ALIGN;
        if (done == 0 && r != 0) clen = clen + RD_ALIGN - r;
      end else begin
        clen = l;
      end
      if (vcfg.converting) begin
        if (dof >= {16'd0, vcfg.boundary}) begin
          key = vcfg.reencrypt ? KEY_TEMP : KEY_NONE;
        end else if (dof + clen > {16'd0, vcfg.boundary}) begin
          clen = {16'd0, vcfg.boundary} - dof;
        end
      end
      if (clen > rem || clen == 0 || n == MAX_RESULTS - 1) clen = rem;
      if (key != KEY_NONE) tw = vcfg.redirect ? dof : dof - hl;
      c.status = STATUS_OK;
      c.disk_offset = dof[47:0];
      c.chunk_bytes = clen[21:0];
      c.buffer_offset = done[21:0];
      c.key_select = key;
      c.tweak_offset = tw[47:0];
      c.discontinuous = disc;
      c.last = (clen == rem);
      chunk_q.push_back(c);
      done = done + clen;
      n++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    chunk_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.disk_offset = out_tdata[47:0];
      got.chunk_bytes = out_tdata[69:48];
      got.buffer_offset = out_tdata[91:70];
      got.key_select = out_tdata[93:92];
      got.tweak_offset = out_tdata[141:94];
      got.discontinuous = out_tdata[142];
      got.last = out_tlast;
      if (chunk_q.size() == 0) begin
        report_mismatch("chunk transfer with no request pending");
      end else begin
        want = chunk_q.pop_front();
        check_field("status", got.status, want.status);
        check_field("disk_offset", got.disk_offset, want.disk_offset);
        check_field("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
        check_field("buffer_offset", got.buffer_offset, want.buffer_offset);
        check_field("key_select", got.key_select, want.key_select);
        check_field("tweak_offset", got.tweak_offset, want.tweak_offset);
        check_field("discontinuous", got.discontinuous, want.discontinuous);
        check_field("last", got.last, want.last);
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_request(input logic op, input logic [47:0] off,
                              input logic [31:0] len, input logic sole);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, sole, len, off};
    do @(posedge clk); while (!in_tready);
    split_request(op, off, len, sole);
  endtask

  // drop valid, wait out every pending chunk, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input volume_cfg_t c);
    write_reg(REG_REDIRECT_ENABLE, {47'd0, c.redirect});
    write_reg(REG_HEADER_LENGTH, {27'd0, c.header_len});
    write_reg(REG_STORAGE_OFFSET, c.storage);
    write_reg(REG_VOLUME_SIZE, c.volume);
    write_reg(REG_SSD_CHUNKING, {47'd0, c.ssd});
    write_reg(REG_CONVERSION_ACTIVE, {47'd0, c.converting});
    write_reg(REG_ENCRYPTED_BOUNDARY, c.boundary);
    write_reg(REG_REENCRYPT_MODE, {47'd0, c.reencrypt});
    cfg_valid <= 1'b0;
    vcfg = c;
  endtask

  function automatic volume_cfg_t volume_setup(input logic redirect, input logic [20:0] hl,
                                               input logic [47:0] storage,
                                               input logic [47:0] volume, input logic ssd,
                                               input logic converting,
                                               input logic [47:0] boundary,
                                               input logic reencrypt);
    volume_cfg_t c;
    c.redirect = redirect;
    c.header_len = hl;
    c.storage = storage;
    c.volume = volume;
    c.ssd = ssd;
    c.converting = converting;
    c.boundary = boundary;
    c.reencrypt = reencrypt;
    return c;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[47:0];
  endfunction

  function automatic volume_cfg_t random_config(output logic [47:0] hot);
    volume_cfg_t c;
    logic [63:0] t;
    c = '0;
    c.redirect = $urandom_range(0, 1) != 0;
    case ($urandom_range(0, 3))
      0: t = 64'd0;
      1: t = 64'd1048576;
      2: t = 64'd512 * $urandom_range(1, 128);
      default: t = {32'd0, $urandom_range(0, 1048576)};
    endcase
    c.header_len = t[20:0];
    case ($urandom_range(0, 3))
      0: c.volume = TOP48[47:0];
      1: c.volume = 48'h4000_0000;
      2: c.volume = rand48() | 48'h8000_0000;
      default: c.volume = 48'h100_0000;
    endcase
    hot = '0;
    if (c.volume > 48'h200_0000 && $urandom_range(0, 2) != 0) begin
      t = {16'd0, rand48()} % {16'd0, c.volume - 48'h200_0000};
      hot = t[47:0];
    end
    case ($urandom_range(0, 2))
      0: begin
        t = {16'd0, hot} + $urandom_range(0, 4194304);
        c.storage = t[47:0];
      end
      1: c.storage = rand48();
      default: c.storage = TOP48[47:0];
    endcase
    c.ssd = $urandom_range(0, 3) != 0;
    c.converting = $urandom_range(0, 1) != 0;
    t = {16'd0, hot} + $urandom_range(0, 8388608);
    if ($urandom_range(0, 1) != 0) t[8:0] = '0;
    c.boundary = t[47:0];
    if ($urandom_range(0, 7) == 0) c.boundary = '0;
    c.reencrypt = $urandom_range(0, 1) != 0;
    return c;
  endfunction

  function automatic logic [31:0] pick_length();
    logic [31:0] n;
    case ($urandom_range(0, 9))
      0, 1, 2: n = 32'd512 * $urandom_range(1, 255);
      3, 4, 5, 6: n = 32'd512 * $urandom_range(256, 4096);
      7: n = MAX_REQ[31:0];
      8: n = SSD_MIN[31:0];
      default: n = SSD_MIN[31:0] - SECTOR[31:0];
    endcase
    return n;
  endfunction

  function automatic void pick_request(input volume_cfg_t c, input logic [47:0] hot,
                                       output logic op, output logic [47:0] off,
                                       output logic [31:0] len, output logic sole);
    int kind;
    logic [63:0] t;
    kind = $urandom_range(0, 99);
    op = $urandom_range(0, 1) != 0;
    sole = $urandom_range(0, 7) != 0;
    len = pick_length();
    if (kind < 90) begin
      if (kind < 65) begin
        off = next_offset;
      end else if (kind < 75) begin
        off = hot;
      end else if (kind < 82) begin
        t = {16'd0, rand48()} % ({16'd0, c.volume} - {32'd0, len} + 1);
        off = t[47:0];
      end else begin
        op = 1'b1;
        t = {16'd0, c.storage} - $urandom_range(0, 4096);
        off = t[47:0];
      end
      // restart the run when it would fall off the end of the volume
      t = {16'd0, off} + {32'd0, len};
      if (kind < 82 && t > {16'd0, c.volume}) off = hot;
    end else begin
      off = rand48();
      len = $urandom();
      if ($urandom_range(0, 1) != 0) len = len & 32'h003F_FE00;
    end
  endfunction

  task automatic test_reset_state();
    send_request(1'b1, 48'd0, 32'd512, 1'b1);
    settle();
  endtask

  task automatic test_refusals();
    load_config(volume_setup(1'b1, 21'd65536, 48'h10_0000, 48'h400_0000,
                             1'b0, 1'b0, 48'd0, 1'b0));
    send_request(1'b0, 48'h2000, 32'd0, 1'b1);
    send_request(1'b0, 48'h2000, 32'd1000, 1'b1);
    send_request(1'b0, 48'h2000, MAX_REQ[31:0] + SECTOR[31:0], 1'b1);
    send_request(1'b0, 48'h3FF_FE00, 32'd1024, 1'b1);
    send_request(1'b1, 48'hF_FE00, 32'd1024, 1'b1);
    send_request(1'b1, 48'h11_0000, 32'd512, 1'b0);
    send_request(1'b0, 48'h10_0000, 32'd4096, 1'b1);
    send_request(1'b1, 48'h10_0000, 32'd0, 1'b1);
    send_request(1'b1, TOP48[47:0], 32'hFFFF_FFFF, 1'b1);
    settle();
  endtask

  task automatic test_header_redirect();
    load_config(volume_setup(1'b1, 21'd32768, 48'h2000_0000, 48'h4000_0000,
                             1'b0, 1'b0, 48'd0, 1'b0));
    send_request(1'b0, 48'd0, 32'd65536, 1'b1);
    send_request(1'b1, 48'h4000, 32'd8192, 1'b1);
    settle();
  endtask

  task automatic test_ssd_chunking();
    load_config(volume_setup(1'b0, 21'd8192, 48'd0, 48'h4000_0000,
                             1'b1, 1'b0, 48'd0, 1'b0));
    send_request(1'b0, 48'd0, 32'h1200, 1'b1);
    send_request(1'b0, next_offset, MAX_REQ[31:0], 1'b1);
    send_request(1'b1, next_offset, MAX_REQ[31:0], 1'b1);
    send_request(1'b0, next_offset, SSD_MIN[31:0], 1'b1);
    send_request(1'b0, next_offset, SSD_MIN[31:0], 1'b0);
    send_request(1'b1, next_offset, SSD_MIN[31:0] - SECTOR[31:0], 1'b1);
    settle();
  endtask

  task automatic test_conversion_boundary();
    load_config(volume_setup(1'b1, 21'd0, 48'd0, 48'h4000_0000,
                             1'b0, 1'b1, 48'h10_0200, 1'b0));
    send_request(1'b0, 48'h10_0000, 32'd4096, 1'b1);
    send_request(1'b1, 48'h20_0000, 32'd512, 1'b1);
    settle();
    load_config(volume_setup(1'b1, 21'd0, 48'd0, 48'h4000_0000,
                             1'b0, 1'b1, 48'h10_0200, 1'b1));
    send_request(1'b0, 48'h10_0000, 32'd4096, 1'b1);
    send_request(1'b0, 48'd0, 32'd512, 1'b1);
    settle();
  endtask

  task automatic test_extremes();
    load_config(volume_setup(1'b0, 21'h10_0000, TOP48[47:0], TOP48[47:0],
                             1'b1, 1'b1, TOP48[47:0], 1'b1));
    send_request(1'b0, 48'hFFFF_FFE0_0000, MAX_REQ[31:0], 1'b1);
    send_request(1'b0, 48'hFFFF_FFDF_FFFF, MAX_REQ[31:0], 1'b1);
    settle();
    load_config(volume_setup(1'b1, 21'h10_0000, TOP48[47:0], TOP48[47:0],
                             1'b0, 1'b1, 48'd0, 1'b0));
    send_request(1'b1, 48'd0, MAX_REQ[31:0], 1'b1);
    send_request(1'b1, 48'hFFFF_FFFF_FE00, 32'd512, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic();
    volume_cfg_t c;
    logic [47:0] hot, off;
    logic [31:0] len;
    logic        op, sole;
    for (int p = 0; p < 10; p++) begin
      no_idle = (p % 4 == 3);
      c = random_config(hot);
      load_config(c);
      for (int i = 0; i < 35; i++) begin
        pick_request(c, hot, op, off, len, sole);
        send_request(op, off, len, sole);
      end
      settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    vcfg = '0;
    vcfg.redirect = 1'b1;
    next_offset = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_refusals();
    test_header_redirect();
    test_ssd_chunking();
    test_conversion_boundary();
    test_extremes();
    test_random_traffic();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(12_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/drcs_pkg.sv
hdl/drcs_alu.sv
hdl/disk_request_chunk_splitter.sv
sim/tb.sv
